[design/ssh_pkg.sv]
`timescale 1ns / 1ps

package ssh_pkg;

  localparam int NumSwitchesDef = 8;
  localparam int LevelW         = 8;
  localparam int CfgW           = 8;
  localparam int CfgIdxW        = 3;

  typedef enum logic [2:0] {
    EV_CLICK     = 3'd0,
    EV_RELEASE   = 3'd1,
    EV_HOLD      = 3'd2,
    EV_LONG_HOLD = 3'd3,
    EV_REPEAT    = 3'd4,
    EV_STATUS    = 3'd5
  } ev_code_e;

  localparam logic [CfgIdxW-1:0] CFG_ACTION_DELAY   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TIME      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_HOLD_TIME = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_LIMIT     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_MASK    = 3'd5;

  typedef struct packed {
    logic [7:0] action_delay;
    logic [6:0] hold_time;
    logic [6:0] long_hold_time;
    logic [7:0] repeat_delay;
    logic [6:0] hold_limit;
  } cfg_t;

  // per-lane findings of one tick: primary event and repeat event
  typedef struct packed {
    logic     a_valid;
    ev_code_e a_code;
    logic     b_valid;
  } ev_t;

endpackage

[design/ssh_in_if.sv]
`timescale 1ns / 1ps

interface ssh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] levels;

  modport source (output valid, output levels, input ready);
  modport sink (input valid, input levels, output ready);
endinterface

[design/ssh_out_if.sv]
`timescale 1ns / 1ps

interface ssh_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] switch_index;
  logic [2:0] event_code;
  logic [7:0] on_flags;
  logic       last;

  modport source (output valid, output switch_index, output event_code, output on_flags,
                  output last, input ready);
  modport sink (input valid, input switch_index, input event_code, input on_flags,
                input last, output ready);
endinterface

[design/switch_scanner_hold_repeat_unit.sv]
`timescale 1ns / 1ps

// channel | dir | beat payload                                   | handshake
// in_i    | in  | levels[7:0]                                    | valid/ready
// out_o   | out | switch_index, event_code, on_flags, last       | valid/ready
// cfg     | in  | cfg_idx_i[2:0], cfg_data_i[7:0]                | cfg_we_i
//
// All switch lanes update in the cycle that a tick is taken.
// Its events plus one status beat leave one per cycle while out_o is
// ready, so a tick gives at most 17 beats for eight switches.
// Beats pass through a pending buffer, the tick being drained and the
// output register; one tick waits pending while the previous one drains.
// Reset clears all switch state and loads the register defaults.
// Output stalls back up into the pending buffer, then into in_i.ready.

module switch_scanner_hold_repeat_unit
  import ssh_pkg::*;
#(
  parameter int NUM_SWITCHES = NumSwitchesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ssh_in_if.sink             in_i,
  ssh_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t                     cfg_q;
  logic [LevelW-1:0]        invert_q;
  logic                     accept;
  logic                     ready;
  logic [NUM_SWITCHES-1:0]  active;
  logic [NUM_SWITCHES-1:0]  on_next;
  ev_t  [NUM_SWITCHES-1:0]  lane_ev;
  logic [7:0]               flags;
  ev_code_e                 out_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.action_delay   <= 8'd0;
      cfg_q.hold_time      <= 7'd50;
      cfg_q.long_hold_time <= 7'd100;
      cfg_q.repeat_delay   <= 8'd10;
      cfg_q.hold_limit     <= 7'd127;
      invert_q             <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTION_DELAY:   cfg_q.action_delay   <= cfg_data_i;
        CFG_HOLD_TIME:      cfg_q.hold_time      <= cfg_data_i[6:0];
        CFG_LONG_HOLD_TIME: cfg_q.long_hold_time <= cfg_data_i[6:0];
        CFG_REPEAT_DELAY:   cfg_q.repeat_delay   <= cfg_data_i;
        CFG_HOLD_LIMIT:     cfg_q.hold_limit     <= cfg_data_i[6:0];
        CFG_INVERT_MASK:    invert_q             <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept     = in_i.valid && ready;
  assign in_i.ready = ready;

  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (i < LevelW) begin
        active[i] = in_i.levels[i] ^ invert_q[i];
      end else begin
        active[i] = 1'b0;
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (i < NUM_SWITCHES) begin
        flags[i] = on_next[i];
      end else begin
        flags[i] = 1'b0;
      end
    end
  end

  for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_lane
    ssh_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (accept),
      .active_i (active[g]),
      .cfg_i    (cfg_q),
      .ev_o     (lane_ev[g]),
      .on_o     (on_next[g])
    );
  end

  ssh_merge #(
    .NumSwitches (NUM_SWITCHES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .ev_i        (lane_ev),
    .flags_i     (flags),
    .ready_o     (ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_index_o (out_o.switch_index),
    .out_code_o  (out_code),
    .out_flags_o (out_o.on_flags),
    .out_last_o  (out_o.last)
  );

  assign out_o.event_code = out_code;

endmodule

[design/ssh_lane.sv]
`timescale 1ns / 1ps

module ssh_lane
  import ssh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic active_i,
  input  cfg_t cfg_i,
  output ev_t  ev_o,
  output logic on_o
);

  logic       was_q, was_d;
  logic       on_q, on_d;
  logic [7:0] dly_q, dly_d;
  logic [6:0] hold_q, hold_d;
  logic [7:0] rep_q, rep_d;

  always_comb begin
    was_d       = was_q;
    on_d        = on_q;
    dly_d       = dly_q;
    hold_d      = hold_q;
    rep_d       = rep_q;
    ev_o        = '0;
    ev_o.a_code = EV_CLICK;

    if (active_i && !was_d) begin
      was_d = 1'b1;
      dly_d = cfg_i.action_delay;
    end else if (!active_i && was_d) begin
      if (on_d) begin
        ev_o.a_valid = 1'b1;
        ev_o.a_code  = EV_RELEASE;
        on_d         = 1'b0;
      end
      was_d = 1'b0;
    end

    if (was_d) begin
      if (!on_d) begin
        if (dly_d == 8'd0) begin
          ev_o.a_valid = 1'b1;
          ev_o.a_code  = EV_CLICK;
          on_d         = 1'b1;
          hold_d       = 7'd0;
          rep_d        = 8'd0;
        end else begin
          dly_d = dly_d - 8'd1;
        end
      end else begin
        if (hold_d < cfg_i.hold_limit) begin
          if (hold_d == cfg_i.hold_time) begin
            ev_o.a_valid = 1'b1;
            ev_o.a_code  = EV_HOLD;
            rep_d        = cfg_i.repeat_delay;
          end else if (hold_d == cfg_i.long_hold_time) begin
            ev_o.a_valid = 1'b1;
            ev_o.a_code  = EV_LONG_HOLD;
          end
          hold_d = hold_d + 7'd1;
        end
        if (rep_d != 8'd0) begin
          rep_d = rep_d - 8'd1;
          if (rep_d == 8'd0) begin
            ev_o.b_valid = 1'b1;
            rep_d        = cfg_i.repeat_delay;
          end
        end
      end
    end
  end

  assign on_o = on_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_q  <= 1'b0;
      on_q   <= 1'b0;
      dly_q  <= '0;
      hold_q <= '0;
      rep_q  <= '0;
    end else if (step_i) begin
      was_q  <= was_d;
      on_q   <= on_d;
      dly_q  <= dly_d;
      hold_q <= hold_d;
      rep_q  <= rep_d;
    end
  end

endmodule

[design/ssh_merge.sv]
`timescale 1ns / 1ps

module ssh_merge
  import ssh_pkg::*;
#(
  parameter int NumSwitches = NumSwitchesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ev_t [NumSwitches-1:0]  ev_i,
  input  logic [7:0]             flags_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             out_index_o,
  output ev_code_e               out_code_o,
  output logic [7:0]             out_flags_o,
  output logic                   out_last_o
);

  localparam int MaskW = 2 * NumSwitches;
  localparam int SelW  = $clog2(MaskW);
  localparam int LaneW = (NumSwitches > 1) ? $clog2(NumSwitches) : 1;

  // pending tick (filled on input beat)
  logic                   pend_valid_q;
  logic [MaskW-1:0]       pend_mask_q;
  ev_code_e               pend_code_q [NumSwitches];
  logic [7:0]             pend_flags_q;

  // tick being drained
  logic                   act_valid_q;
  logic [MaskW-1:0]       act_mask_q;
  ev_code_e               act_code_q [NumSwitches];
  logic [7:0]             act_flags_q;

  // output register
  logic                   out_valid_q;
  logic [2:0]             out_index_q;
  ev_code_e               out_code_q;
  logic [7:0]             out_flags_q;
  logic                   out_last_q;

  logic                   found;
  logic [SelW-1:0]        sel;
  logic [LaneW-1:0]       lane;
  logic                   emit, done, act_load;
  logic [MaskW-1:0]       ev_mask;

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = 0; k < MaskW; k++) begin
      if (!found && act_mask_q[k]) begin
        found = 1'b1;
        sel   = SelW'(k);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumSwitches; i++) begin
      ev_mask[2*i]   = ev_i[i].a_valid;
      ev_mask[2*i+1] = ev_i[i].b_valid;
    end
  end

  assign lane     = LaneW'(sel >> 1);
  assign emit     = act_valid_q && (!out_valid_q || out_ready_i);
  assign done     = emit && !found;
  assign act_load = pend_valid_q && (!act_valid_q || done);
  assign ready_o  = !pend_valid_q || act_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      act_valid_q  <= 1'b0;
      act_mask_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_i) begin
        pend_valid_q <= 1'b1;
      end else if (act_load) begin
        pend_valid_q <= 1'b0;
      end

      if (act_load) begin
        act_valid_q <= 1'b1;
        act_mask_q  <= pend_mask_q;
      end else if (emit) begin
        if (found) begin
          act_mask_q[sel] <= 1'b0;
        end else begin
          act_valid_q <= 1'b0;
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_mask_q  <= ev_mask;
      pend_flags_q <= flags_i;
      for (int i = 0; i < NumSwitches; i++) begin
        pend_code_q[i] <= ev_i[i].a_code;
      end
    end
    if (act_load) begin
      act_flags_q <= pend_flags_q;
      for (int i = 0; i < NumSwitches; i++) begin
        act_code_q[i] <= pend_code_q[i];
      end
    end
    if (emit) begin
      out_flags_q <= act_flags_q;
      if (found) begin
        out_index_q <= 3'(lane);
        out_code_q  <= sel[0] ? EV_REPEAT : act_code_q[lane];
        out_last_q  <= 1'b0;
      end else begin
        out_index_q <= 3'd0;
        out_code_q  <= EV_STATUS;
        out_last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_code_o  = out_code_q;
  assign out_flags_o = out_flags_q;
  assign out_last_o  = out_last_q;

endmodule

[design/ssh_checker.sv]
`timescale 1ns / 1ps

module ssh_checker
  import ssh_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_index_i,
  input logic [2:0] out_code_i,
  input logic [7:0] out_flags_i,
  input logic       out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_code_i)
      && $stable(out_index_i) && $stable(out_flags_i) && $stable(out_last_i))
    else $error("output beat dropped or changed under stall");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_code_i == EV_STATUS)))
    else $error("last flag does not match status beat");

  a_status_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_index_i == 3'd0)
    else $error("status beat carries a switch index");

  a_click_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_code_i == EV_CLICK) |-> out_flags_i[out_index_i])
    else $error("click on a switch that is not on");

  a_release_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_code_i == EV_RELEASE) |-> !out_flags_i[out_index_i])
    else $error("release on a switch that is still on");

endmodule

bind switch_scanner_hold_repeat_unit ssh_checker u_ssh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.switch_index),
  .out_code_i  (out_o.event_code),
  .out_flags_i (out_o.on_flags),
  .out_last_i  (out_o.last)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ssh_pkg::*;

  localparam int NSW        = 8;
  localparam int LIMIT      = 300000;
  localparam int SETTLE     = 8;
  localparam int HOLD_OFF   = 400;
  localparam int PHASE_TICK = 35;

  typedef struct {
    logic [2:0] sw;
    ev_code_e   code;
    logic [7:0] flags;
    logic       last;
  } beat_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [7:0]         data;
    logic [7:0]         levels;
    bit                 typed;
    ev_code_e           t_code;
    logic [7:0]         t_mask;
    logic [7:0]         t_flags;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  ssh_in_if  in_if ();
  ssh_out_if out_if ();

  switch_scanner_hold_repeat_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scanner copy: registers and per-switch state
  logic [7:0] m_action_delay;
  logic [6:0] m_hold_time;
  logic [6:0] m_long_hold_time;
  logic [7:0] m_repeat_delay;
  logic [6:0] m_hold_limit;
  logic [7:0] m_invert;
  logic       sw_was_active [NSW];
  logic [7:0] sw_delay      [NSW];
  logic [6:0] sw_hold       [NSW];
  logic [7:0] sw_repeat     [NSW];
  logic       sw_on         [NSW];

  beat_t    tick_beats [17];
  int       tick_n;
  beat_t    exp_beats [$];
  dir_row_t dir_rows [$];

  int  cycle_count = 0;
  int  n_errors    = 0;
  int  n_ticks     = 0;
  int  n_beats     = 0;
  int  ev_seen [6];
  int  src_idle    = 0;
  int  sink_stall  = 0;
  bit  hold_req    = 1'b0;

  function automatic void add_event(input int sw, input ev_code_e code);
    tick_beats[tick_n] = '{sw: 3'(sw), code: code, flags: 8'h00, last: 1'b0};
    tick_n++;
  endfunction

  function automatic void scan_tick(input logic [7:0] lv);
    logic       act;
    logic [7:0] fl;
    tick_n = 0;
    fl     = 8'h00;
    for (int i = 0; i < NSW; i++) begin
      act = lv[i] ^ m_invert[i];
      if (act && !sw_was_active[i]) begin
        sw_was_active[i] = 1'b1;
        sw_delay[i]      = m_action_delay;
      end else if (!act && sw_was_active[i]) begin
        if (sw_on[i]) begin
          add_event(i, EV_RELEASE);
          sw_on[i] = 1'b0;
        end
        sw_was_active[i] = 1'b0;
      end
      if (sw_was_active[i]) begin
        if (!sw_on[i]) begin
          if (sw_delay[i] == 8'd0) begin
            add_event(i, EV_CLICK);
            sw_on[i]     = 1'b1;
            sw_hold[i]   = 7'd0;
            sw_repeat[i] = 8'd0;
          end else begin
            sw_delay[i] = sw_delay[i] - 8'd1;
          end
        end else begin
          if (sw_hold[i] < m_hold_limit) begin
            if (sw_hold[i] == m_hold_time) begin
              add_event(i, EV_HOLD);
              sw_repeat[i] = m_repeat_delay;
            end else if (sw_hold[i] == m_long_hold_time) begin
              add_event(i, EV_LONG_HOLD);
            end
            sw_hold[i] = sw_hold[i] + 7'd1;
          end
          if (sw_repeat[i] > 8'd0) begin
            sw_repeat[i] = sw_repeat[i] - 8'd1;
            if (sw_repeat[i] == 8'd0) begin
              add_event(i, EV_REPEAT);
              sw_repeat[i] = m_repeat_delay;
            end
          end
        end
      end
      fl[i] = sw_on[i];
    end
    for (int k = 0; k < tick_n; k++) tick_beats[k].flags = fl;
    tick_beats[tick_n] = '{sw: 3'd0, code: EV_STATUS, flags: fl, last: 1'b1};
    tick_n++;
  endfunction

  function automatic void row_tick(input logic [7:0] lv);
    dir_row_t r;
    r = '{kind: ROW_TICK, idx: '0, data: '0, levels: lv, typed: 1'b0,
          t_code: EV_STATUS, t_mask: '0, t_flags: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_typed(input logic [7:0] lv, input ev_code_e code,
                                    input logic [7:0] mask, input logic [7:0] flags);
    dir_row_t r;
    r = '{kind: ROW_TICK, idx: '0, data: '0, levels: lv, typed: 1'b1,
          t_code: code, t_mask: mask, t_flags: flags};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    dir_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, levels: '0, typed: 1'b0,
          t_code: EV_STATUS, t_mask: '0, t_flags: '0};
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] next_levels(input logic [7:0] lv);
    logic [7:0] flip;
    flip = 8'h00;
    if ($urandom_range(9) == 0) return 8'($urandom);
    for (int i = 0; i < NSW; i++) if ($urandom_range(9) == 0) flip[i] = 1'b1;
    return lv ^ flip;
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    n_errors++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ACTION_DELAY:   m_action_delay   = data;
      CFG_HOLD_TIME:      m_hold_time      = data[6:0];
      CFG_LONG_HOLD_TIME: m_long_hold_time = data[6:0];
      CFG_REPEAT_DELAY:   m_repeat_delay   = data;
      CFG_HOLD_LIMIT:     m_hold_limit     = data[6:0];
      CFG_INVERT_MASK:    m_invert         = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // block goes idle: input low, every beat out, then a settle wait
  task automatic drain();
    in_if.valid <= 1'b0;
    cfg_we      <= 1'b0;
    @(posedge clk_i);
    while (exp_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [7:0] lv, input bit typed, input ev_code_e code,
                           input logic [7:0] mask, input logic [7:0] flags);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.levels <= lv;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    n_ticks++;
    scan_tick(lv);
    if (typed) begin
      for (int i = 0; i < NSW; i++)
        if (mask[i]) exp_beats.push_back('{sw: 3'(i), code: code, flags: flags, last: 1'b0});
      exp_beats.push_back('{sw: 3'd0, code: EV_STATUS, flags: flags, last: 1'b1});
    end else begin
      for (int k = 0; k < tick_n; k++) exp_beats.push_back(tick_beats[k]);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, exp_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin : out_check
    beat_t b;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      n_beats++;
      if (out_if.event_code < 3'd6) ev_seen[out_if.event_code]++;
      if (exp_beats.size() == 0) begin
        report($sformatf("beat sw=%0d code=%0d with nothing expected",
                         out_if.switch_index, out_if.event_code));
      end else begin
        b = exp_beats.pop_front();
        if (out_if.switch_index !== b.sw)
          report($sformatf("switch_index %0d, want %0d", out_if.switch_index, b.sw));
        if (out_if.event_code !== b.code)
          report($sformatf("event_code %0d, want %0d (sw %0d)", out_if.event_code,
                           b.code, b.sw));
        if (out_if.on_flags !== b.flags)
          report($sformatf("on_flags %h, want %h", out_if.on_flags, b.flags));
        if (out_if.last !== b.last)
          report($sformatf("last %b, want %b", out_if.last, b.last));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        for (int c = 0; c < HOLD_OFF; c++) begin
          out_if.ready <= 1'b0;
          @(posedge clk_i);
        end
        hold_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  initial begin
    logic [7:0] lv;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.levels <= 8'h00;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    m_action_delay   = 8'd0;
    m_hold_time      = 7'd50;
    m_long_hold_time = 7'd100;
    m_repeat_delay   = 8'd10;
    m_hold_limit     = 7'd127;
    m_invert         = 8'h00;
    for (int i = 0; i < NSW; i++) begin
      sw_was_active[i] = 1'b0;
      sw_delay[i]      = 8'd0;
      sw_hold[i]       = 7'd0;
      sw_repeat[i]     = 8'd0;
      sw_on[i]         = 1'b0;
    end
    for (int c = 0; c < 6; c++) ev_seen[c] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset defaults, all-on/all-off, active-low pins
    row_typed(8'h00, EV_STATUS, 8'h00, 8'h00);
    row_typed(8'hFF, EV_CLICK, 8'hFF, 8'hFF);
    row_typed(8'h00, EV_RELEASE, 8'hFF, 8'h00);
    row_cfg(CFG_INVERT_MASK, 8'hFF);
    row_typed(8'hFF, EV_STATUS, 8'h00, 8'h00);
    row_typed(8'h00, EV_CLICK, 8'hFF, 8'hFF);
    row_typed(8'hFF, EV_RELEASE, 8'hFF, 8'h00);
    // countdown, hold equal to long hold, repeat of one, saturation
    row_cfg(CFG_INVERT_MASK, 8'h00);
    row_cfg(CFG_ACTION_DELAY, 8'd2);
    row_cfg(CFG_HOLD_TIME, 8'd0);
    row_cfg(CFG_LONG_HOLD_TIME, 8'd0);
    row_cfg(CFG_REPEAT_DELAY, 8'd1);
    row_cfg(CFG_HOLD_LIMIT, 8'd3);
    repeat (7) row_tick(8'h01);
    row_tick(8'h80);
    // extremes
    row_cfg(CFG_ACTION_DELAY, 8'hFF);
    row_cfg(CFG_REPEAT_DELAY, 8'd0);
    row_cfg(CFG_HOLD_TIME, 8'hFF);
    row_cfg(CFG_LONG_HOLD_TIME, 8'h7F);
    row_cfg(CFG_HOLD_LIMIT, 8'd0);
    row_tick(8'h80);
    row_typed(8'h00, EV_STATUS, 8'h00, 8'h00);
    // long hold ahead of hold, slow repeat
    row_cfg(CFG_ACTION_DELAY, 8'd0);
    row_cfg(CFG_HOLD_TIME, 8'd5);
    row_cfg(CFG_LONG_HOLD_TIME, 8'd2);
    row_cfg(CFG_HOLD_LIMIT, 8'h7F);
    row_cfg(CFG_REPEAT_DELAY, 8'hFF);
    repeat (7) row_tick(8'hAA);
    row_typed(8'h00, EV_RELEASE, 8'hAA, 8'h00);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_tick(dir_rows[r].levels, dir_rows[r].typed, dir_rows[r].t_code,
                  dir_rows[r].t_mask, dir_rows[r].t_flags);
      end
    end

    lv = 8'h00;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(CFG_ACTION_DELAY, 8'($urandom_range(3)));
      write_reg(CFG_HOLD_TIME, 8'($urandom_range(6)) | 8'($urandom_range(1) << 7));
      write_reg(CFG_LONG_HOLD_TIME, 8'($urandom_range(8)) | 8'($urandom_range(1) << 7));
      write_reg(CFG_REPEAT_DELAY, 8'($urandom_range(3)));
      write_reg(CFG_HOLD_LIMIT, ($urandom_range(3) == 0) ? 8'd127 : 8'($urandom_range(10)));
      write_reg(CFG_INVERT_MASK, 8'($urandom));
      case (p)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 81; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 81; end
        3: begin src_idle = 15; sink_stall = 15; end
        default: begin
          src_idle   = 0;
          sink_stall = 0;
          hold_req   = 1'b1;
        end
      endcase
      for (int t = 0; t < PHASE_TICK; t++) begin
        lv = next_levels(lv);
        send_tick(lv, 1'b0, EV_STATUS, 8'h00, 8'h00);
      end
    end
    drain();

    $display("Ran %0d scan ticks in %0d cycles, %0d output beats checked, %0d mismatches",
             n_ticks, cycle_count, n_beats, n_errors);
    $display("Events: click %0d, release %0d, hold %0d, long hold %0d, repeat %0d",
             ev_seen[EV_CLICK], ev_seen[EV_RELEASE], ev_seen[EV_HOLD],
             ev_seen[EV_LONG_HOLD], ev_seen[EV_REPEAT]);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
